@@ sv/alist_pkg.sv @@
package alist_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int DATA_W       = 32;
  localparam int MODE_W       = 3;
  localparam int POS_W        = 6;
  localparam int ENT_W        = 7;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT = 3'd0,
    MODE_DELETE = 3'd1,
    MODE_SEARCH = 3'd2,
    MODE_LIST   = 3'd3,
    MODE_SORT   = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  element;
    logic [POS_W-1:0]          position;
    logic [ENT_W-1:0]          entries;
    logic                      last;
  } res_t;

endpackage

@@ sv/alist_ram.sv @@
module alist_ram #(
  parameter int WIDTH = alist_pkg::DATA_W,
  parameter int DEPTH = alist_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/alist_ctrl.sv @@
module alist_ctrl #(
  parameter int CAPACITY = alist_pkg::CAPACITY_DEF,
  parameter int AW       = $clog2(CAPACITY),
  parameter int CW       = $clog2(CAPACITY + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [alist_pkg::MODE_W-1:0]      in_mode,
  input  logic [alist_pkg::DATA_W-1:0]      in_value,
  output logic                              res_valid,
  input  logic                              res_ready,
  output alist_pkg::res_t                   res,
  output logic                              ram_we,
  output logic [AW-1:0]                     ram_waddr,
  output logic [alist_pkg::DATA_W-1:0]      ram_wdata,
  output logic                              ram_re,
  output logic [AW-1:0]                     ram_raddr,
  input  logic [alist_pkg::DATA_W-1:0]      ram_rdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_EMIT, S_SCAN, S_SHIFT, S_LRD, S_LEM, S_SRD, S_SLD, S_SSC, S_SWB
  } state_t;

  state_t                          state_r, state_nxt;
  logic [CW-1:0]                   count_r, count_nxt;
  alist_pkg::mode_t                mode_r, mode_nxt;
  logic [alist_pkg::DATA_W-1:0]    value_r, value_nxt;
  alist_pkg::status_t              status_r, status_nxt;
  logic [CW-1:0]                   idx_r, idx_nxt;
  logic [CW-1:0]                   chk_r, chk_nxt;
  logic                            pend_r, pend_nxt;
  logic [CW-1:0]                   base_r, base_nxt;
  logic [alist_pkg::DATA_W-1:0]    cur_r, cur_nxt;

  logic                            full;
  logic [CW-1:0]                   chk_dec;
  logic                            idx_at_end;
  logic                            sort_done;

  assign full       = (count_r == CW'(CAPACITY));
  assign chk_dec    = chk_r - 1'b1;
  assign idx_at_end = (({1'b0, idx_r} + 1'b1) == {1'b0, count_r});
  assign sort_done  = (({1'b0, base_r} + 1'b1) >= {1'b0, count_r});

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    mode_nxt   = mode_r;
    value_nxt  = value_r;
    status_nxt = status_r;
    idx_nxt    = idx_r;
    chk_nxt    = chk_r;
    pend_nxt   = pend_r;
    base_nxt   = base_r;
    cur_nxt    = cur_r;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    in_ready   = (state_r == S_IDLE);
    res_valid  = 1'b0;
    res.status   = status_r;
    res.element  = '0;
    res.position = '0;
    res.entries  = alist_pkg::ENT_W'(count_r);
    res.last     = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt  = alist_pkg::mode_t'(in_mode);
          value_nxt = in_value;
          unique case (alist_pkg::mode_t'(in_mode))
            alist_pkg::MODE_INSERT: begin
              if (full) begin
                status_nxt = alist_pkg::ST_FULL;
              end else begin
                ram_we     = 1'b1;
                ram_waddr  = count_r[AW-1:0];
                ram_wdata  = in_value;
                count_nxt  = count_r + 1'b1;
                status_nxt = alist_pkg::ST_OK;
              end
              state_nxt = S_EMIT;
            end
            alist_pkg::MODE_DELETE, alist_pkg::MODE_SEARCH: begin
              idx_nxt   = '0;
              pend_nxt  = 1'b0;
              state_nxt = S_SCAN;
            end
            alist_pkg::MODE_LIST: begin
              if (count_r == '0) begin
                status_nxt = alist_pkg::ST_EMPTY;
                state_nxt  = S_EMIT;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_LRD;
              end
            end
            alist_pkg::MODE_SORT: begin
              base_nxt  = '0;
              state_nxt = S_SRD;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (pend_r && (ram_rdata == value_r)) begin
          if (mode_r == alist_pkg::MODE_DELETE) begin
            idx_nxt   = chk_r + 1'b1;
            pend_nxt  = 1'b0;
            state_nxt = S_SHIFT;
          end else begin
            status_nxt = alist_pkg::ST_OK;
            state_nxt  = S_EMIT;
          end
        end else if (idx_r < count_r) begin
          ram_re    = 1'b1;
          ram_raddr = idx_r[AW-1:0];
          pend_nxt  = 1'b1;
          chk_nxt   = idx_r;
          idx_nxt   = idx_r + 1'b1;
        end else begin
          pend_nxt   = 1'b0;
          status_nxt = alist_pkg::ST_NOT_FOUND;
          state_nxt  = S_EMIT;
        end
      end
      S_SHIFT: begin
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = chk_dec[AW-1:0];
          ram_wdata = ram_rdata;
        end
        if (idx_r < count_r) begin
          ram_re    = 1'b1;
          ram_raddr = idx_r[AW-1:0];
          pend_nxt  = 1'b1;
          chk_nxt   = idx_r;
          idx_nxt   = idx_r + 1'b1;
        end else begin
          pend_nxt   = 1'b0;
          count_nxt  = count_r - 1'b1;
          status_nxt = alist_pkg::ST_OK;
          state_nxt  = S_EMIT;
        end
      end
      S_LRD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r[AW-1:0];
        state_nxt = S_LEM;
      end
      S_LEM: begin
        res_valid    = 1'b1;
        res.status   = alist_pkg::ST_OK;
        res.element  = ram_rdata;
        res.position = alist_pkg::POS_W'(idx_r[AW-1:0]);
        res.last     = idx_at_end;
        if (res_ready) begin
          if (idx_at_end) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_LRD;
          end
        end
      end
      S_SRD: begin
        if (sort_done) begin
          status_nxt = alist_pkg::ST_OK;
          state_nxt  = S_EMIT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = base_r[AW-1:0];
          state_nxt = S_SLD;
        end
      end
      S_SLD: begin
        cur_nxt   = ram_rdata;
        idx_nxt   = base_r + 1'b1;
        pend_nxt  = 1'b0;
        state_nxt = S_SSC;
      end
      S_SSC: begin
        // keep the running minimum, push the larger value out to its slot
        if (pend_r && ($signed(cur_r) > $signed(ram_rdata))) begin
          ram_we    = 1'b1;
          ram_waddr = chk_r[AW-1:0];
          ram_wdata = cur_r;
          cur_nxt   = ram_rdata;
        end
        if (idx_r < count_r) begin
          ram_re    = 1'b1;
          ram_raddr = idx_r[AW-1:0];
          pend_nxt  = 1'b1;
          chk_nxt   = idx_r;
          idx_nxt   = idx_r + 1'b1;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_SWB;
        end
      end
      S_SWB: begin
        ram_we    = 1'b1;
        ram_waddr = base_r[AW-1:0];
        ram_wdata = cur_r;
        base_nxt  = base_r + 1'b1;
        state_nxt = S_SRD;
      end
      S_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
    mode_r   <= mode_nxt;
    value_r  <= value_nxt;
    status_r <= status_nxt;
    idx_r    <= idx_nxt;
    chk_r    <= chk_nxt;
    base_r   <= base_nxt;
    cur_r    <= cur_nxt;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("read and write to the same entry in one cycle");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_mode == alist_pkg::MODE_INSERT) && !full)
    |=> (count_r == $past(count_r) + 1'b1))
    else $error("insert did not grow the list");

  a_list_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LEM) |-> (count_r != '0))
    else $error("list walk on an empty list");

endmodule

@@ sv/alist_obuf.sv @@
module alist_obuf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            res_valid,
  output logic            res_ready,
  input  alist_pkg::res_t res,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [47:0]     out_tdata,
  output logic [1:0]      out_tuser,
  output logic            out_tlast
);

  alist_pkg::res_t data_r;
  logic            vld_r;

  assign res_ready  = !vld_r || out_tready;
  assign out_tvalid = vld_r;
  assign out_tdata  = {3'b000, data_r.entries, data_r.position, data_r.element};
  assign out_tuser  = data_r.status;
  assign out_tlast  = data_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (res_ready) begin
      vld_r <= res_valid;
    end
    if (res_valid && res_ready) begin
      data_r <= res;
    end
  end

endmodule

@@ sv/array_list_engine.sv @@
// channel | dir | tdata (lowest bit up)                       | tuser     | tlast
// in_     | in  | value[31:0]                                 | mode[2:0] | -
// out_    | out | element[31:0] position[37:32] entries[44:38] | status    | last
//
// the time that insert, search, delete, list and sort take is set by the one read and one write
// port of the store ram
// reset clears the entry count, the control state and the output valid flag, not the store ram
// results pass through one output register; the engine waits while it is full and out_tready is low
module array_list_engine #(
  parameter int CAPACITY = alist_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value
  input  logic [2:0]  in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // element, position, entries, zero fill
  output logic [1:0]  out_tuser,  // status
  output logic        out_tlast
);

  localparam int AW = $clog2(CAPACITY);

  logic                          res_valid;
  logic                          res_ready;
  alist_pkg::res_t               res;
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [alist_pkg::DATA_W-1:0]  ram_wdata;
  logic                          ram_re;
  logic [AW-1:0]                 ram_raddr;
  logic [alist_pkg::DATA_W-1:0]  ram_rdata;

  alist_ram #(
    .WIDTH (alist_pkg::DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  alist_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_mode   (in_tuser),
    .in_value  (in_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  alist_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
